>>> src/qled_pkg.sv
// ----------------------------------------------------------------------------
// qled_pkg
// Shared types and constants for the quoted literal escape decoder.
// ----------------------------------------------------------------------------
package qled_pkg;

  localparam int unsigned ACCUM_WIDTH_DEF = 64;
  localparam int unsigned MAX_RESULTS     = 3;

  // Decoder mode
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_TEXT     = 3'd1,
    MODE_ESC      = 3'd2,
    MODE_HEX_NONE = 3'd3,
    MODE_HEX_DIG  = 3'd4,
    MODE_OCT      = 3'd5
  } mode_e;

  // Error codes carried with each result word
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_UNTERM    = 3'd1,
    ERR_HEX_EMPTY = 3'd2,
    ERR_HEX_RANGE = 3'd3,
    ERR_OCT_RANGE = 3'd4,
    ERR_UNKNOWN   = 3'd5
  } err_e;

  // One result word
  typedef struct packed {
    logic       data_valid;
    logic [7:0] decoded_byte;
    logic [2:0] error_code;
    logic       token_done;
    logic       run_last;
  } res_t;

endpackage

>>> src/qled_decode.sv
// ----------------------------------------------------------------------------
// qled_decode
// Next-state and result logic for one literal byte, up to three results.
// ----------------------------------------------------------------------------
module qled_decode
  import qled_pkg::*;
#(
  parameter int unsigned ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
  input  logic [7:0]             byte_i,
  input  logic                   first_i,
  input  logic                   last_i,
  input  mode_e                  mode_i,
  input  logic [7:0]             quote_i,
  input  logic [ACCUM_WIDTH-1:0] acc_i,
  input  logic [1:0]             oct_i,
  output mode_e                  mode_o,
  output logic [7:0]             quote_o,
  output logic [ACCUM_WIDTH-1:0] acc_o,
  output logic [1:0]             oct_o,
  output res_t [2:0]             res_o,
  output logic [1:0]             cnt_o
);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_LX     = 8'h78;

  function automatic res_t mk(logic v, logic [7:0] b, err_e e);
    res_t r;
    r              = '0;
    r.data_valid   = v;
    r.decoded_byte = b;
    r.error_code   = e;
    return r;
  endfunction

  function automatic logic is_pending(mode_e m);
    return (m == MODE_ESC) || (m == MODE_HEX_NONE) || (m == MODE_HEX_DIG) ||
           (m == MODE_OCT);
  endfunction

  // Result for an escape closed before its next byte
  function automatic res_t flush_res(mode_e m, logic [ACCUM_WIDTH-1:0] a);
    res_t r;
    logic big;
    big = |a[ACCUM_WIDTH-1:8];
    case (m)
      MODE_ESC:      r = mk(1'b1, CH_BSLASH, ERR_NONE);
      MODE_HEX_NONE: r = mk(1'b1, 8'h00, ERR_HEX_EMPTY);
      MODE_HEX_DIG:  r = mk(1'b1, a[7:0], big ? ERR_HEX_RANGE : ERR_NONE);
      MODE_OCT:      r = mk(1'b1, a[7:0], big ? ERR_OCT_RANGE : ERR_NONE);
      default:       r = '0;
    endcase
    return r;
  endfunction

  logic                   hex_ok;
  logic [3:0]             hex_val;
  logic                   oct_dig;
  logic [ACCUM_WIDTH-1:0] acc_hex;
  logic [ACCUM_WIDTH-1:0] acc_oct;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = byte_i[3:0];
    if (byte_i inside {[8'h30:8'h39]}) begin
      hex_val = byte_i[3:0];
    end else if ((byte_i inside {[8'h61:8'h66]}) || (byte_i inside {[8'h41:8'h46]})) begin
      hex_val = byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign oct_dig = (byte_i[7:3] == 5'b00110);
  // Saturate when a further digit would overflow the accumulator
  assign acc_hex = (acc_i[ACCUM_WIDTH-1:ACCUM_WIDTH-4] == 4'd0) ?
                   {acc_i[ACCUM_WIDTH-5:0], hex_val} : '1;
  assign acc_oct = {acc_i[ACCUM_WIDTH-4:0], byte_i[2:0]};

  // Content byte handling
  mode_e                  hb_mode;
  logic [ACCUM_WIDTH-1:0] hb_acc;
  logic [1:0]             hb_oct;
  logic                   hb_s1v;
  res_t                   hb_s1;
  logic                   hb_s2v;
  res_t                   hb_s2;
  logic                   hb_text;

  always_comb begin
    hb_mode = mode_i;
    hb_acc  = acc_i;
    hb_oct  = oct_i;
    hb_s1v  = 1'b0;
    hb_s1   = '0;
    hb_s2v  = 1'b0;
    hb_s2   = '0;
    hb_text = 1'b0;
    case (mode_i)
      MODE_ESC: begin
        hb_mode = MODE_TEXT;
        hb_s2v  = 1'b1;
        case (byte_i)
          CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH: hb_s2 = mk(1'b1, byte_i, ERR_NONE);
          CH_LA: hb_s2 = mk(1'b1, 8'd7, ERR_NONE);
          CH_LB: hb_s2 = mk(1'b1, 8'd8, ERR_NONE);
          CH_LF: hb_s2 = mk(1'b1, 8'd12, ERR_NONE);
          CH_LN: hb_s2 = mk(1'b1, 8'd10, ERR_NONE);
          CH_LR: hb_s2 = mk(1'b1, 8'd13, ERR_NONE);
          CH_LT: hb_s2 = mk(1'b1, 8'd9, ERR_NONE);
          CH_LV: hb_s2 = mk(1'b1, 8'd11, ERR_NONE);
          CH_LX: begin
            hb_s2v  = 1'b0;
            hb_mode = MODE_HEX_NONE;
            hb_acc  = '0;
          end
          default: begin
            if (oct_dig) begin
              hb_s2v  = 1'b0;
              hb_mode = MODE_OCT;
              hb_acc  = ACCUM_WIDTH'(byte_i[2:0]);
              hb_oct  = 2'd1;
            end else begin
              hb_s2 = mk(1'b1, byte_i, ERR_UNKNOWN);
            end
          end
        endcase
      end
      MODE_HEX_NONE, MODE_HEX_DIG: begin
        if (hex_ok) begin
          hb_acc  = acc_hex;
          hb_mode = MODE_HEX_DIG;
        end else begin
          hb_s1v  = 1'b1;
          hb_s1   = flush_res(mode_i, acc_i);
          hb_text = 1'b1;
        end
      end
      MODE_OCT: begin
        if (oct_dig) begin
          if (oct_i >= 2'd2) begin
            // third digit closes the escape
            hb_s1v  = 1'b1;
            hb_s1   = flush_res(MODE_OCT, acc_oct);
            hb_mode = MODE_TEXT;
            hb_acc  = '0;
            hb_oct  = '0;
          end else begin
            hb_acc = acc_oct;
            hb_oct = oct_i + 2'd1;
          end
        end else begin
          hb_s1v  = 1'b1;
          hb_s1   = flush_res(mode_i, acc_i);
          hb_text = 1'b1;
        end
      end
      default: hb_text = 1'b1;
    endcase
    if (hb_text) begin
      hb_acc = '0;
      hb_oct = '0;
      if (byte_i == CH_BSLASH) begin
        hb_mode = MODE_ESC;
      end else begin
        hb_mode = MODE_TEXT;
        hb_s2v  = 1'b1;
        hb_s2   = mk(1'b1, byte_i, ERR_NONE);
      end
    end
  end

  // Slot order: unterminated mark, flush, byte result, final flush
  logic [3:0] sv;
  res_t [3:0] slot;
  logic       done;
  logic [1:0] n;

  always_comb begin
    sv      = '0;
    slot    = '0;
    done    = 1'b0;
    mode_o  = mode_i;
    quote_o = quote_i;
    acc_o   = acc_i;
    oct_o   = oct_i;
    if (first_i) begin
      quote_o = byte_i;
      mode_o  = MODE_TEXT;
      acc_o   = '0;
      oct_o   = '0;
      if (last_i) begin
        sv[0]   = 1'b1;
        slot[0] = mk(1'b0, 8'h00, ERR_UNTERM);
        done    = 1'b1;
        mode_o  = MODE_IDLE;
      end
    end else if (mode_i == MODE_IDLE) begin
      sv = '0;
    end else if (last_i) begin
      if (byte_i == quote_i) begin
        sv[1]   = 1'b1;
        slot[1] = is_pending(mode_i) ? flush_res(mode_i, acc_i) : mk(1'b0, 8'h00, ERR_NONE);
      end else begin
        sv[0]   = 1'b1;
        slot[0] = mk(1'b0, 8'h00, ERR_UNTERM);
        sv[1]   = hb_s1v;
        slot[1] = hb_s1;
        sv[2]   = hb_s2v;
        slot[2] = hb_s2;
        sv[3]   = is_pending(hb_mode);
        slot[3] = flush_res(hb_mode, hb_acc);
      end
      done   = 1'b1;
      mode_o = MODE_IDLE;
      acc_o  = '0;
      oct_o  = '0;
    end else begin
      sv[1]   = hb_s1v;
      slot[1] = hb_s1;
      sv[2]   = hb_s2v;
      slot[2] = hb_s2;
      mode_o  = hb_mode;
      acc_o   = hb_acc;
      oct_o   = hb_oct;
    end
  end

  // Pack the live slots down into result order
  always_comb begin
    n     = '0;
    res_o = '0;
    for (int k = 0; k < 4; k++) begin
      if (sv[k] && (n != 2'd3)) begin
        res_o[n] = slot[k];
        n        = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      res_o[n - 2'd1].run_last   = 1'b1;
      res_o[n - 2'd1].token_done = done;
    end
  end

  assign cnt_o = n;

endmodule

>>> src/qled_outq.sv
// ----------------------------------------------------------------------------
// qled_outq
// Result register: holds the words of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module qled_outq
  import qled_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t [2:0] res_i,
  input  logic [1:0] cnt_i,
  output logic       free_o,
  output logic       valid_o,
  input  logic       ready_i,
  output res_t       res_o
);

  res_t [2:0] res_q;
  logic [1:0] rd_q, rd_d;
  logic [1:0] rem_q, rem_d;
  logic       pop;

  assign valid_o = (rem_q != 2'd0);
  assign pop     = valid_o && ready_i;
  // Free when empty or when the last held word leaves in this cycle
  assign free_o  = (rem_q == 2'd0) || ((rem_q == 2'd1) && ready_i);
  assign res_o   = res_q[rd_q];

  always_comb begin
    rd_d  = rd_q;
    rem_d = rem_q;
    if (load_i) begin
      rd_d  = '0;
      rem_d = cnt_i;
    end else if (pop) begin
      rd_d  = rd_q + 2'd1;
      rem_d = rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      rem_q <= '0;
    end else begin
      rd_q  <= rd_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> src/quoted_literal_escape_decoder.sv
// ----------------------------------------------------------------------------
// quoted_literal_escape_decoder
// Decodes the bytes of a quoted C literal into the byte values it stands for.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the raw literal on the s_axis channel, one byte per word, starting
//   with the opening quote (tuser high) and ending with tlast on the final
//   byte. Decoded words leave on m_axis: tdata carries the byte and the error
//   code, tuser flags a valid byte and the end of the literal, tlast marks the
//   last word caused by one input byte. A byte may cause zero to three words.
//   A word appears in the cycle after its byte is accepted. Throughput:
//   one byte per cycle while each byte yields at most one word and the
//   receiver is ready; a byte that yields more than one word holds
//   s_axis_tready low until its last word leaves the single output register, which drains one word per cycle.
//   Reset clears the decoder to idle: bytes arriving before an opening quote
//   are dropped without a result. When the receiver stalls, the held words
//   stay put and s_axis_tready drops once the next byte has nowhere to go.
// ----------------------------------------------------------------------------
module quoted_literal_escape_decoder
  import qled_pkg::*;
#(
  parameter int unsigned ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_in
  input  logic        s_axis_tuser,  // [0] first_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] decoded_byte, [10:8] error_code
  output logic [1:0]  m_axis_tuser,  // [0] data_valid, [1] token_done
  output logic        m_axis_tlast   // run_last
);

  // Decoder state
  mode_e                  mode_q, mode_d;
  logic [7:0]             quote_q, quote_d;
  logic [ACCUM_WIDTH-1:0] acc_q, acc_d;
  logic [1:0]             oct_q, oct_d;

  res_t [2:0] res;
  logic [1:0] cnt;
  logic       accept;
  res_t       out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  qled_decode #(
    .ACCUM_WIDTH(ACCUM_WIDTH)
  ) u_decode (
    .byte_i (s_axis_tdata),
    .first_i(s_axis_tuser),
    .last_i (s_axis_tlast),
    .mode_i (mode_q),
    .quote_i(quote_q),
    .acc_i  (acc_q),
    .oct_i  (oct_q),
    .mode_o (mode_d),
    .quote_o(quote_d),
    .acc_o  (acc_d),
    .oct_o  (oct_d),
    .res_o  (res),
    .cnt_o  (cnt)
  );

  // Advance the state only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      quote_q <= '0;
      acc_q   <= '0;
      oct_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      acc_q   <= acc_d;
      oct_q   <= oct_d;
    end
  end

  qled_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .res_i  (res),
    .cnt_i  (cnt),
    .free_o (s_axis_tready),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .res_o  (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.error_code, out_res.decoded_byte};
  assign m_axis_tuser = {out_res.token_done, out_res.data_valid};
  assign m_axis_tlast = out_res.run_last;

endmodule
